// File: rtl/smst_pkg.sv
package smst_pkg;

	localparam int PkgSlots = 8;
	localparam int MaxResults = 8;
	localparam int RepW = $clog2(MaxResults + 1);

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_REGISTER = 3'd1,
		OP_UNREG    = 3'd2,
		OP_START    = 3'd3,
		OP_STOP     = 3'd4,
		OP_REINIT   = 3'd5,
		OP_RESTART  = 3'd6,
		OP_STATUS   = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		CODE_OK           = 3'd0,
		CODE_ALREADY_REG  = 3'd1,
		CODE_NOT_REG      = 3'd2,
		CODE_ALREADY_RUN  = 3'd3,
		CODE_ALREADY_STOP = 3'd4,
		CODE_FIRED        = 3'd5
	} code_t;

	typedef enum logic [1:0] {
		STAT_STOPPED = 2'd0,
		STAT_RUNNING = 2'd1,
		STAT_UNKNOWN = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_SETTLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic exec;
		logic tick_start;
		logic rd_en;
		logic scan_en;
		logic flush;
	} ctl_t;

	typedef struct packed {
		logic out_free;
		logic scan_hold;
		logic pend_valid;
	} sts_t;

endpackage

// File: rtl/multi_slot_software_timer_unit.sv
// Bank of SLOTS software timer slots driven by commands on the input channel.
// A command (register, unregister, start, stop, reinit, restart, get status)
// is executed on its transfer and produces exactly one result with last set.
// A tick goes from its transfer to a sweep that reads the count and timeout
// memories one slot per cycle through their single read port, then a settle
// state that lets the last slot's update land, then a scan of the fired slots
// one per cycle unless the output side stalls, and then a flush of the last
// pending result; no new input is taken until the flush is done. A tick yields
// one fired result per fired slot in ascending order (at most eight, the final
// one with last set) and none when nothing fires. The tick period register is
// written through the cfg channel, which always takes its transfer; the user
// must write it only while the block is idle, and the block does not enforce it.
module multi_slot_software_timer_unit #(
	parameter int SLOTS = smst_pkg::PkgSlots
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [2:0]  slot,
	input  logic [31:0] timeout,
	input  logic        periodic,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  code,
	output logic [2:0]  slot_out,
	output logic [1:0]  status,
	output logic        last
);

	localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	smst_pkg::ctl_t ctl;
	smst_pkg::sts_t sts;
	logic [SlotW-1:0] idx;

	assign cfg_ready = 1'b1;

	smst_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.opcode(opcode),
		.in_ready(in_ready),
		.sts(sts),
		.ctl(ctl),
		.idx(idx)
	);

	smst_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.idx(idx),
		.sts(sts),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.opcode(opcode),
		.slot(slot),
		.timeout(timeout),
		.periodic(periodic),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.code(code),
		.slot_out(slot_out),
		.status(status),
		.last(last)
	);

	// A new item is only taken when the output register can take its result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("input taken while the output register is blocked");

	// Every command transfer leaves its result in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && opcode != smst_pkg::OP_TICK) |=> (out_valid && last))
		else $error("command transfer produced no final result");

	// A tick occupies the block while it sweeps the slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && opcode == smst_pkg::OP_TICK) |=> !in_ready)
		else $error("input accepted during a tick sweep");

endmodule

// File: rtl/smst_dp.sv
module smst_dp #(
	parameter int SLOTS = smst_pkg::PkgSlots,
	localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smst_pkg::ctl_t     ctl,
	input  logic [SlotW-1:0]   idx,
	output smst_pkg::sts_t     sts,
	input  logic               cfg_valid,
	input  logic [31:0]        cfg_data,
	input  logic [2:0]         opcode,
	input  logic [2:0]         slot,
	input  logic [31:0]        timeout,
	input  logic               periodic,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [2:0]         code,
	output logic [2:0]         slot_out,
	output logic [1:0]         status,
	output logic               last
);

	localparam int ExtW = ((SlotW > 3) ? SlotW : 3) + 1;

	logic [31:0] period_q;
	logic [SLOTS-1:0] reg_q;
	logic [SLOTS-1:0] run_q;
	logic [SLOTS-1:0] per_q;
	logic [SLOTS-1:0] fire_q;
	logic [31:0] cnt_mem [SLOTS];
	logic [31:0] to_mem [SLOTS];

	logic [31:0] cnt_s1;
	logic [31:0] to_s1;
	logic [SlotW-1:0] idx_s1;
	logic vld_s1;

	logic [ExtW-1:0] slot_ext;
	logic [SlotW-1:0] cmd_idx;
	logic inbank;
	logic cur_reg;
	logic cur_run;
	logic new_reg;
	logic new_run;
	logic clr_cnt;
	logic wr_to;
	smst_pkg::code_t cmd_code;
	smst_pkg::stat_t cmd_stat;

	logic [32:0] sum;
	logic [31:0] sat;
	logic fire;
	logic active;
	logic cnt_we;
	logic [SlotW-1:0] cnt_wa;
	logic [31:0] cnt_wd;

	logic pend_q;
	logic [SlotW-1:0] pend_idx_q;
	logic pend_per_q;
	logic [smst_pkg::RepW-1:0] rep_q;
	logic take;
	logic hold;
	logic step;
	logic push_fire;
	logic push_flush;
	logic out_free;

	logic out_valid_q;
	logic [2:0] code_q;
	logic [2:0] slot_out_q;
	logic [1:0] status_q;
	logic last_q;

	// Command decode. A slot outside the bank can never be registered.
	assign slot_ext = ExtW'(slot);
	assign inbank = slot_ext < ExtW'(SLOTS);
	assign cmd_idx = slot_ext[SlotW-1:0];
	assign cur_reg = inbank && reg_q[cmd_idx];
	assign cur_run = inbank && run_q[cmd_idx];

	always_comb begin
		new_reg = cur_reg;
		new_run = cur_run;
		cmd_code = smst_pkg::CODE_OK;
		clr_cnt = 1'b0;
		wr_to = 1'b0;
		case (smst_pkg::op_t'(opcode))
			smst_pkg::OP_REGISTER: begin
				if (!inbank) begin
					cmd_code = smst_pkg::CODE_NOT_REG;
				end else if (cur_reg) begin
					cmd_code = smst_pkg::CODE_ALREADY_REG;
				end else begin
					new_reg = 1'b1;
					new_run = 1'b0;
					clr_cnt = 1'b1;
					wr_to = 1'b1;
				end
			end
			smst_pkg::OP_STATUS: begin
				cmd_code = smst_pkg::CODE_OK;
			end
			default: begin
				if (!cur_reg) begin
					cmd_code = smst_pkg::CODE_NOT_REG;
				end else begin
					case (smst_pkg::op_t'(opcode))
						smst_pkg::OP_UNREG: begin
							new_reg = 1'b0;
							new_run = 1'b0;
						end
						smst_pkg::OP_START: begin
							if (cur_run) cmd_code = smst_pkg::CODE_ALREADY_RUN;
							else new_run = 1'b1;
						end
						smst_pkg::OP_STOP: begin
							if (!cur_run) cmd_code = smst_pkg::CODE_ALREADY_STOP;
							else new_run = 1'b0;
						end
						smst_pkg::OP_REINIT: begin
							new_run = 1'b0;
							clr_cnt = 1'b1;
						end
						smst_pkg::OP_RESTART: begin
							new_run = 1'b1;
							clr_cnt = 1'b1;
						end
						default: begin
							new_run = cur_run;
						end
					endcase
				end
			end
		endcase
		if (!new_reg) cmd_stat = smst_pkg::STAT_UNKNOWN;
		else if (new_run) cmd_stat = smst_pkg::STAT_RUNNING;
		else cmd_stat = smst_pkg::STAT_STOPPED;
	end

	// Tick evaluation of the slot read in the previous cycle.
	assign sum = {1'b0, cnt_s1} + {1'b0, period_q};
	assign sat = sum[32] ? '1 : sum[31:0];
	assign fire = sat >= to_s1;
	assign active = vld_s1 && reg_q[idx_s1] && run_q[idx_s1];

	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = idx_s1;
		cnt_wd = sat;
		if (active) begin
			cnt_we = 1'b1;
			if (fire && per_q[idx_s1]) cnt_wd = '0;
		end else if (ctl.exec && clr_cnt) begin
			cnt_we = 1'b1;
			cnt_wa = cmd_idx;
			cnt_wd = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (ctl.rd_en) cnt_s1 <= cnt_mem[idx];
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && wr_to) to_mem[cmd_idx] <= timeout;
		if (ctl.rd_en) to_s1 <= to_mem[idx];
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && wr_to) per_q[cmd_idx] <= periodic;
		if (vld_s1) fire_q[idx_s1] <= active && fire;
		if (ctl.rd_en) idx_s1 <= idx;
		if (step) begin
			pend_idx_q <= idx;
			pend_per_q <= per_q[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			reg_q <= '0;
			run_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cfg_valid) period_q <= cfg_data;
			vld_s1 <= ctl.rd_en;
			if (ctl.exec && inbank) begin
				reg_q[cmd_idx] <= new_reg;
				run_q[cmd_idx] <= new_run;
			end else if (active && fire && !per_q[idx_s1]) begin
				run_q[idx_s1] <= 1'b0;
			end
		end
	end

	// Result scan. The newest fired slot waits in a pending register so that
	// the final result of a tick can carry the last flag.
	assign out_free = !out_valid_q || out_ready;
	assign take = ctl.scan_en && fire_q[idx] &&
		(rep_q < smst_pkg::RepW'(smst_pkg::MaxResults));
	assign hold = take && pend_q && !out_free;
	assign step = take && !hold;
	assign push_fire = step && pend_q;
	assign push_flush = ctl.flush && pend_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			rep_q <= '0;
		end else if (ctl.tick_start) begin
			pend_q <= 1'b0;
			rep_q <= '0;
		end else if (step) begin
			pend_q <= 1'b1;
			rep_q <= rep_q + 1'b1;
		end else if (push_flush) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.exec || push_fire || push_flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			code_q <= cmd_code;
			slot_out_q <= slot;
			status_q <= cmd_stat;
			last_q <= 1'b1;
		end else if (push_fire || push_flush) begin
			code_q <= smst_pkg::CODE_FIRED;
			slot_out_q <= 3'(pend_idx_q);
			status_q <= pend_per_q ? smst_pkg::STAT_RUNNING : smst_pkg::STAT_STOPPED;
			last_q <= push_flush;
		end
	end

	assign sts.out_free = out_free;
	assign sts.scan_hold = hold;
	assign sts.pend_valid = pend_q;

	assign out_valid = out_valid_q;
	assign code = code_q;
	assign slot_out = slot_out_q;
	assign status = status_q;
	assign last = last_q;

endmodule

// File: rtl/smst_ctrl.sv
module smst_ctrl #(
	parameter int SLOTS = smst_pkg::PkgSlots,
	localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [2:0]       opcode,
	output logic             in_ready,
	input  smst_pkg::sts_t   sts,
	output smst_pkg::ctl_t   ctl,
	output logic [SlotW-1:0] idx
);

	smst_pkg::state_t state_q;
	smst_pkg::state_t state_d;
	logic [SlotW-1:0] idx_q;
	logic accept;
	logic is_tick;
	logic last_idx;

	assign in_ready = (state_q == smst_pkg::ST_IDLE) && sts.out_free;
	assign accept = in_valid && in_ready;
	assign is_tick = opcode == smst_pkg::OP_TICK;
	assign last_idx = idx_q == SlotW'(SLOTS - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			smst_pkg::ST_IDLE: begin
				if (accept && is_tick) state_d = smst_pkg::ST_SWEEP;
			end
			smst_pkg::ST_SWEEP: begin
				if (last_idx) state_d = smst_pkg::ST_SETTLE;
			end
			smst_pkg::ST_SETTLE: begin
				state_d = smst_pkg::ST_SCAN;
			end
			smst_pkg::ST_SCAN: begin
				if (last_idx && !sts.scan_hold) state_d = smst_pkg::ST_FLUSH;
			end
			smst_pkg::ST_FLUSH: begin
				if (!sts.pend_valid || sts.out_free) state_d = smst_pkg::ST_IDLE;
			end
			default: begin
				state_d = smst_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			smst_pkg::ST_IDLE: begin
				ctl.exec = accept && !is_tick;
				ctl.tick_start = accept && is_tick;
			end
			smst_pkg::ST_SWEEP: begin
				ctl.rd_en = 1'b1;
			end
			smst_pkg::ST_SCAN: begin
				ctl.scan_en = 1'b1;
			end
			smst_pkg::ST_FLUSH: begin
				ctl.flush = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smst_pkg::ST_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				smst_pkg::ST_SWEEP: begin
					idx_q <= last_idx ? '0 : idx_q + 1'b1;
				end
				smst_pkg::ST_SCAN: begin
					if (!sts.scan_hold) idx_q <= last_idx ? '0 : idx_q + 1'b1;
				end
				default: begin
					idx_q <= '0;
				end
			endcase
		end
	end

	assign idx = idx_q;

endmodule
